### sv/mdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_pkg: shared constants and types
// Widths, register indexes, status codes and the divider request type.
// ----------------------------------------------------------------------------
package mdd_pkg;
  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int DEPTH_W = 16;
  localparam int COORD_W = 24;
  localparam int QUOT_W = 34;

  localparam logic [1:0] REG_FOCAL_X = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y = 2'd1;
  localparam logic [1:0] REG_PRINCIPAL_X = 2'd2;
  localparam logic [1:0] REG_PRINCIPAL_Y = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_STALE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic signed [COORD_W-1:0] SAT_HI = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] SAT_LO = -24'sh800000;

  typedef struct packed {
    logic start;
    logic [QUOT_W-1:0] dividend;
    logic [17:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

### sv/mdd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdd channel interfaces
// Sample, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface mdd_in_if;
  logic valid;
  logic ready;
  logic [15:0] depth_sample;
  logic last_sample;
  logic [15:0] center_u;
  logic [15:0] center_v;
  logic signed [31:0] request_time;
  logic signed [31:0] frame_time;
  modport source(output valid, depth_sample, last_sample, center_u, center_v,
                 request_time, frame_time, input ready);
  modport sink(input valid, depth_sample, last_sample, center_u, center_v,
               request_time, frame_time, output ready);
endinterface

interface mdd_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [15:0] point_z;
  modport source(output valid, status, point_x, point_y, point_z, input ready);
  modport sink(input valid, status, point_x, point_y, point_z, output ready);
endinterface

interface mdd_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/mdd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdd_div: restoring divider
// One quotient bit per cycle while busy; a new start restarts the division.
// ----------------------------------------------------------------------------
module mdd_div
  import mdd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output logic busy,
  output logic [QUOT_W-1:0] quot
);
  localparam int STEP_W = $clog2(QUOT_W + 1);
  logic [STEP_W-1:0] steps;
  logic [QUOT_W-1:0] dvd;
  logic [17:0] dsr;
  logic [18:0] rem;
  logic [18:0] trial;

  always_comb begin
    trial = {rem[17:0], dvd[QUOT_W-1]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      steps <= STEP_W'(QUOT_W);
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      // shift one dividend bit in, subtract when it fits
      if (!trial[18]) begin
        rem <= trial;
      end else begin
        rem <= {rem[17:0], dvd[QUOT_W-1]};
      end
      quot <= {quot[QUOT_W-2:0], ~trial[18]};
      dvd <= {dvd[QUOT_W-2:0], 1'b0};
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/median_depth_deprojection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_depth_deprojection_unit: median depth and pinhole deprojection
// Collect valid depth samples, select their median and deproject the
// region centre to a 3-D point in millimetres.
// ----------------------------------------------------------------------------
// channel  role   payload
// smp      sink   depth_sample, last_sample, center_u/v, request/frame_time
// res      source status, point_x, point_y, point_z
// cfg      sink   index, data (focal_x, focal_y, principal_x, principal_y)
//
// Samples that are not last are taken one per cycle. A last beat whose region
// is neither stale nor empty starts a median selection: each candidate is
// fetched, captured, then checked in a compare pass over all n stored samples,
// one memory read per cycle, and up to n candidates are tried per rank; an even
// n searches two ranks. Each coordinate then goes through absolute difference,
// product, divider start, 34 divide steps and capture. A stale or empty region
// goes from the last beat straight to the output state. Reset is synchronous;
// the store needs no clearing. The input is not ready while a region is being
// computed, or while its point waits for a previous point still held.
module median_depth_deprojection_unit
  import mdd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  mdd_in_if.sink smp,
  mdd_out_if.source res,
  mdd_cfg_if.sink cfg
);
  typedef enum logic [3:0] {
    ST_COLLECT, ST_FETCH, ST_CAND, ST_SCAN, ST_MUL, ST_PROD, ST_DIV,
    ST_DIV_WAIT, ST_OUT
  } state_t;

  state_t state;
  logic [DEPTH_W-1:0] store [MAX_SAMPLES];
  logic [DEPTH_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0] count;
  logic smp_keep;             // valid depth with room left in the store
  logic [CNT_W-1:0] count_next;

  logic [15:0] focal_x, focal_y, principal_x, principal_y;
  logic [15:0] cu, cv;

  // median search
  logic [CNT_W-1:0] total;    // samples in the closed region
  logic [CNT_W-1:0] rank;     // rank being searched
  logic [CNT_W-1:0] cand;     // candidate index
  logic [CNT_W-1:0] scan;     // next read index of the compare pass
  logic [CNT_W-1:0] less_cnt, eq_cnt;
  logic [CNT_W-1:0] less_next, eq_next;
  logic [DEPTH_W-1:0] cand_val;
  logic [DEPTH_W-1:0] low_val;  // lower middle for an even count
  logic [DEPTH_W:0] mid_sum;
  logic even_n;
  logic need_upper;
  logic [DEPTH_W-1:0] z;

  // deprojection
  logic axis;                 // 0 x, 1 y
  logic neg;
  logic [15:0] mag;
  logic [16:0] dsub;
  logic [15:0] f_sel, f_div;
  logic [31:0] prod;
  div_req_t dreq;
  logic dbusy;
  logic [QUOT_W-1:0] dquot;
  logic signed [COORD_W-1:0] coord;
  logic signed [COORD_W-1:0] px;
  logic [1:0] pend_status;

  logic signed [32:0] tdiff;
  logic stale;
  logic accept;
  logic res_free;
  logic res_load;

  assign smp.ready = (state == ST_COLLECT);
  // hold register writes off while a region is being computed
  assign cfg.ready = (state == ST_COLLECT);
  assign accept = smp.valid && smp.ready;

  assign smp_keep = smp.depth_sample != 16'h0000 && smp.depth_sample != 16'hFFFF
                    && count != CNT_W'(MAX_SAMPLES);
  assign count_next = count + CNT_W'(smp_keep);

  assign tdiff = 33'(smp.request_time) - 33'(smp.frame_time);
  assign stale = (tdiff > 33'sd1) || (tdiff < -33'sd1);

  // output slot is free when empty or when its point leaves this cycle
  assign res_free = !res.valid || res.ready;
  assign res_load = res_free && ((state == ST_OUT)
                    || (state == ST_DIV_WAIT && axis && !dbusy));

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 16'd6838;
      focal_y <= 16'd6838;
      principal_x <= 16'd6824;
      principal_y <= 16'd3884;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FOCAL_X: focal_x <= cfg.data;
        REG_FOCAL_Y: focal_y <= cfg.data;
        REG_PRINCIPAL_X: principal_x <= cfg.data;
        REG_PRINCIPAL_Y: principal_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // sample store: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && smp_keep) begin
      store[count[ADDR_W-1:0]] <= smp.depth_sample;
    end
    rd_data <= store[rd_addr];
  end

  always_comb begin
    rd_addr = (state == ST_FETCH) ? cand[ADDR_W-1:0] : scan[ADDR_W-1:0];
  end

  // running counts including the entry that arrives this cycle
  always_comb begin
    less_next = less_cnt + CNT_W'(rd_data < cand_val);
    eq_next = eq_cnt + CNT_W'(rd_data == cand_val);
    mid_sum = {1'b0, low_val} + {1'b0, cand_val};
  end

  // divisor, numerator for the current axis; a zero focal length acts as 1
  always_comb begin
    f_sel = axis ? focal_y : focal_x;
    f_div = (f_sel == 16'd0) ? 16'd1 : f_sel;
    dreq.start = (state == ST_DIV);
    dreq.dividend = {1'b0, prod, 1'b0} + QUOT_W'(f_div);
    dreq.divisor = {1'b0, f_div, 1'b0};
  end

  mdd_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot)
  );

  always_comb begin
    dsub = {1'b0, axis ? cv : cu} - {1'b0, axis ? principal_y : principal_x};
  end

  // saturate the rounded magnitude and apply the sign
  always_comb begin
    coord = (dquot > QUOT_W'(SAT_HI)) ? (neg ? SAT_LO : SAT_HI)
            : (neg ? -COORD_W'(dquot) : COORD_W'(dquot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      count <= '0;
      res.valid <= 1'b0;
    end else begin
      // a new point replaces the one leaving; otherwise drop valid on take
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_COLLECT: begin
          if (accept) begin
            count <= smp.last_sample ? '0 : count_next;
            if (smp.last_sample) begin
              cu <= smp.center_u;
              cv <= smp.center_v;
              total <= count_next;
              // lower middle rank, then the upper one when the count is even
              rank <= (count_next - 1'b1) >> 1;
              even_n <= ~count_next[0];
              need_upper <= ~count_next[0];
              cand <= '0;
              if (stale) begin
                pend_status <= STATUS_STALE;
                state <= ST_OUT;
              end else if (count_next == '0) begin
                pend_status <= STATUS_EMPTY;
                state <= ST_OUT;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_FETCH: begin
          // read the candidate this cycle, entry 0 next
          scan <= '0;
          state <= ST_CAND;
        end
        ST_CAND: begin
          cand_val <= rd_data;
          scan <= CNT_W'(1);
          less_cnt <= '0;
          eq_cnt <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // rd_data holds entry scan-1
          less_cnt <= less_next;
          eq_cnt <= eq_next;
          if (scan == total) begin
            if (less_next <= rank && rank < less_next + eq_next) begin
              if (need_upper) begin
                low_val <= cand_val;
                need_upper <= 1'b0;
                rank <= rank + 1'b1;
                cand <= '0;
                state <= ST_FETCH;
              end else begin
                z <= even_n ? mid_sum[DEPTH_W:1] : cand_val;
                axis <= 1'b0;
                state <= ST_MUL;
              end
            end else begin
              cand <= cand + 1'b1;
              state <= ST_FETCH;
            end
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_MUL: begin
          neg <= dsub[16];
          mag <= dsub[16] ? 16'(-dsub) : dsub[15:0];
          state <= ST_PROD;
        end
        ST_PROD: begin
          // product of |d| and z settles into prod
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (!dbusy) begin
            if (!axis) begin
              px <= coord;
              axis <= 1'b1;
              state <= ST_MUL;
            end else if (res_free) begin
              res.status <= STATUS_OK;
              res.point_x <= px;
              res.point_y <= coord;
              res.point_z <= z;
              state <= ST_COLLECT;
            end
          end
        end
        ST_OUT: begin
          // stale or empty region: status only, zero point
          if (res_free) begin
            res.status <= pend_status;
            res.point_x <= '0;
            res.point_y <= '0;
            res.point_z <= '0;
            state <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // product of |d| and z, registered ahead of the divider
  always_ff @(posedge clk) begin
    prod <= 32'(mag) * 32'(z);
  end
endmodule
`default_nettype wire
